### sv/ocpw_pkg.sv
// ----------------------------------------------------------------------------
// ocpw_pkg
// shared types and constants of the cyclic prefix and window core
// ----------------------------------------------------------------------------
package ocpw_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int MAX_IDX_W   = 10;   // enough for the largest symbol length
   localparam int POS_W       = 4;    // flank and tail positions
   localparam int PREFIX_W    = 6;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 6;
   localparam int FIFO_DEPTH  = 4;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_PREFIX_LEN = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_ON  = 2'd1;

   // input opcodes
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_END   = 2'd2;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [MAX_IDX_W-1:0]       idx_type;
   typedef logic [POS_W-1:0]           pos_type;

   typedef enum logic [1:0] {
      CMD_WRITE,
      CMD_SAMPLE,
      CMD_TAIL
   } cmd_kind_type;

   // one unit of work handed from the front to the back
   typedef struct packed {
      cmd_kind_type kind;
      logic         bank;
      idx_type      idx;          // write address or sample address
      idx_type      src;          // delay line source address
      pos_type      pos;          // flank index or tail index
      logic         windowed;
      logic         symbol_last;
      logic         burst_last;
      sample_type   re;
      sample_type   im;
   } cmd_type;

endpackage

### sv/ocpw_front.sv
// ----------------------------------------------------------------------------
// ocpw_front
// accepts items, tracks bank and position state, issues commands
// ----------------------------------------------------------------------------
module ocpw_front #(
   parameter int FFT_LEN     = 64,
   parameter int ROLLOFF_LEN = 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_op,
   input  ocpw_pkg::sample_type          req_sample_re,
   input  ocpw_pkg::sample_type          req_sample_im,
   input  logic [ocpw_pkg::PREFIX_W-1:0] prefix_len,
   input  logic                          window_on,
   input  logic                          fifo_full,
   output logic                          fifo_push,
   output ocpw_pkg::cmd_type             fifo_cmd
);

   localparam int IDX_W     = $clog2(FFT_LEN);
   localparam int RP_W      = $clog2(FFT_LEN + 63);
   localparam int TAIL_LAST = (ROLLOFF_LEN >= 2) ? ROLLOFF_LEN - 2 : 0;
   localparam int WIN_SPAN  = (ROLLOFF_LEN >= 2) ? ROLLOFF_LEN - 1 : 0;
   localparam bit WIN_OK    = (ROLLOFF_LEN >= 2);

   // first read address (start of the prefix) for each prefix length: (-prefix) mod FFT_LEN
   function automatic logic [63:0][IDX_W-1:0] build_start();
      logic [63:0][IDX_W-1:0] t;
      for (int k = 0; k < 64; k++) begin
         t[k] = IDX_W'((FFT_LEN * 64 - k) % FFT_LEN);
      end
      return t;
   endfunction

   localparam logic [63:0][IDX_W-1:0] START_IDX = build_start();

   logic [IDX_W-1:0]              write_pos_ff, write_pos_in;
   logic                          write_bank_ff, write_bank_in;
   logic [1:0]                    banks_full_ff, banks_full_in;
   logic                          read_bank_ff, read_bank_in;
   logic [RP_W-1:0]               read_pos_ff, read_pos_in;
   logic [IDX_W-1:0]              rd_idx_ff, rd_idx_in;
   logic [ocpw_pkg::PREFIX_W-1:0] sym_prefix_ff, sym_prefix_in;
   logic                          burst_ending_ff, burst_ending_in;
   logic [ocpw_pkg::POS_W-1:0]    tail_pos_ff, tail_pos_in;

   logic                          accept;
   logic                          win_active;
   logic [ocpw_pkg::PREFIX_W-1:0] cur_prefix;
   logic [IDX_W-1:0]              cur_idx;
   logic [RP_W-1:0]               last_pos;
   logic [RP_W-1:0]               src_pos;
   logic                          is_last;
   logic                          tail_done;

   assign req_ready  = !fifo_full && !reset;
   assign accept     = req_valid && req_ready;
   assign win_active = window_on && WIN_OK;

   always_comb begin
      write_pos_in    = write_pos_ff;
      write_bank_in   = write_bank_ff;
      banks_full_in   = banks_full_ff;
      read_bank_in    = read_bank_ff;
      read_pos_in     = read_pos_ff;
      rd_idx_in       = rd_idx_ff;
      sym_prefix_in   = sym_prefix_ff;
      burst_ending_in = burst_ending_ff;
      tail_pos_in     = tail_pos_ff;
      fifo_push       = 1'b0;
      fifo_cmd        = '0;
      fifo_cmd.re     = req_sample_re;
      fifo_cmd.im     = req_sample_im;

      cur_prefix = (read_pos_ff == '0) ? prefix_len : sym_prefix_ff;
      cur_idx    = (read_pos_ff == '0) ? START_IDX[prefix_len] : rd_idx_ff;
      last_pos   = RP_W'(cur_prefix) + RP_W'(FFT_LEN - 1);
      is_last    = (read_pos_ff == last_pos);
      src_pos    = (read_pos_ff >= RP_W'(FFT_LEN)) ? read_pos_ff - RP_W'(FFT_LEN)
                                                    : read_pos_ff;
      tail_done  = (tail_pos_ff >= ocpw_pkg::POS_W'(TAIL_LAST));

      if (accept) begin
         case (req_op)
            ocpw_pkg::OP_WRITE: begin
               if (!banks_full_ff[write_bank_ff]) begin
                  fifo_push     = 1'b1;
                  fifo_cmd.kind = ocpw_pkg::CMD_WRITE;
                  fifo_cmd.bank = write_bank_ff;
                  fifo_cmd.idx  = ocpw_pkg::idx_type'(write_pos_ff);
                  if (write_pos_ff == IDX_W'(FFT_LEN - 1)) begin
                     write_pos_in                 = '0;
                     banks_full_in[write_bank_ff] = 1'b1;
                     write_bank_in                = !write_bank_ff;
                  end else begin
                     write_pos_in = write_pos_ff + 1'b1;
                  end
               end
            end
            ocpw_pkg::OP_END: begin
               if (!burst_ending_ff && win_active) begin
                  burst_ending_in = 1'b1;
                  tail_pos_in     = '0;
               end
            end
            ocpw_pkg::OP_READ: begin
               if (read_pos_ff == '0 && burst_ending_ff) begin
                  // tail of the burst before any new symbol
                  fifo_push           = 1'b1;
                  fifo_cmd.kind       = ocpw_pkg::CMD_TAIL;
                  fifo_cmd.pos        = tail_pos_ff;
                  fifo_cmd.burst_last = tail_done;
                  if (tail_done) begin
                     burst_ending_in = 1'b0;
                     tail_pos_in     = '0;
                  end else begin
                     tail_pos_in = tail_pos_ff + 1'b1;
                  end
               end else if (read_pos_ff != '0 || banks_full_ff[read_bank_ff]) begin
                  fifo_push            = 1'b1;
                  fifo_cmd.kind        = ocpw_pkg::CMD_SAMPLE;
                  fifo_cmd.bank        = read_bank_ff;
                  fifo_cmd.idx         = ocpw_pkg::idx_type'(cur_idx);
                  fifo_cmd.src         = ocpw_pkg::idx_type'(src_pos[IDX_W-1:0]);
                  fifo_cmd.pos         = ocpw_pkg::pos_type'(read_pos_ff);
                  fifo_cmd.windowed    = win_active &&
                                         (read_pos_ff < RP_W'(WIN_SPAN));
                  fifo_cmd.symbol_last = is_last;
                  sym_prefix_in        = cur_prefix;
                  rd_idx_in            = (cur_idx == IDX_W'(FFT_LEN - 1)) ? '0
                                                                          : cur_idx + 1'b1;
                  if (is_last) begin
                     read_pos_in                 = '0;
                     banks_full_in[read_bank_ff] = 1'b0;
                     read_bank_in                = !read_bank_ff;
                  end else begin
                     read_pos_in = read_pos_ff + 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_pos_ff    <= '0;
         write_bank_ff   <= 1'b0;
         banks_full_ff   <= '0;
         read_bank_ff    <= 1'b0;
         read_pos_ff     <= '0;
         rd_idx_ff       <= '0;
         sym_prefix_ff   <= '0;
         burst_ending_ff <= 1'b0;
         tail_pos_ff     <= '0;
      end else begin
         write_pos_ff    <= write_pos_in;
         write_bank_ff   <= write_bank_in;
         banks_full_ff   <= banks_full_in;
         read_bank_ff    <= read_bank_in;
         read_pos_ff     <= read_pos_in;
         rd_idx_ff       <= rd_idx_in;
         sym_prefix_ff   <= sym_prefix_in;
         burst_ending_ff <= burst_ending_in;
         tail_pos_ff     <= tail_pos_in;
      end
   end

endmodule

### sv/ocpw_fifo.sv
// ----------------------------------------------------------------------------
// ocpw_fifo
// short command queue between front and back
// ----------------------------------------------------------------------------
module ocpw_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ocpw_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output ocpw_pkg::cmd_type head_cmd
);

   localparam int PTR_W = $clog2(ocpw_pkg::FIFO_DEPTH);

   ocpw_pkg::cmd_type entry_ff [ocpw_pkg::FIFO_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]    count_ff, count_in;
   logic              do_push, do_pop;

   assign full      = (count_ff == (PTR_W + 1)'(ocpw_pkg::FIFO_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_cmd  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### sv/ocpw_back.sv
// ----------------------------------------------------------------------------
// ocpw_back
// sample store, flank multipliers, delay line and output register
// ----------------------------------------------------------------------------
module ocpw_back #(
   parameter int FFT_LEN     = 64,
   parameter int ROLLOFF_LEN = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_avail,
   input  ocpw_pkg::cmd_type    cmd,
   output logic                 cmd_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ocpw_pkg::sample_type rsp_out_re,
   output ocpw_pkg::sample_type rsp_out_im,
   output logic                 rsp_symbol_last,
   output logic                 rsp_burst_last
);

   localparam int IDX_W     = $clog2(FFT_LEN);
   localparam int DLY_DEPTH = (ROLLOFF_LEN >= 3) ? ROLLOFF_LEN - 1 : 2;
   localparam int DLY_W     = $clog2(DLY_DEPTH);
   localparam logic [63:0] PI_Q30 = 64'd3373259426;

   // sin^2(pi*num/(2*ROLLOFF_LEN)) in Q1.15 via truncated Taylor series in Q2.30
   function automatic logic [15:0] sin_sq(input int num);
      logic [63:0] x, x2, term, sum, sq;
      x    = (PI_Q30 * 64'(num)) / 64'(2 * ROLLOFF_LEN);
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int k = 1; k <= 8; k++) begin
         term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      if (sum > (64'd1 << 30)) begin
         sum = 64'd1 << 30;
      end
      sq = (sum * sum + (64'd1 << 44)) >> 45;
      return sq[15:0];
   endfunction

   function automatic logic [15:0][15:0] build_flank(input bit falling);
      logic [15:0][15:0] t;
      t = '0;
      for (int i = 1; i < ROLLOFF_LEN; i++) begin
         t[i - 1] = falling ? sin_sq(ROLLOFF_LEN - i) : sin_sq(i);
      end
      return t;
   endfunction

   localparam logic [15:0][15:0] UP_FLANK   = build_flank(1'b0);
   localparam logic [15:0][15:0] DOWN_FLANK = build_flank(1'b1);

   // sample times flank, rounded half up to Q1.15
   function automatic logic signed [16:0] mul_round(input ocpw_pkg::sample_type s,
                                                    input logic [15:0] f);
      logic signed [33:0] p;
      p = $signed(s) * $signed({1'b0, f});
      p = p + 34'sd16384;
      return p[31:15];
   endfunction

   function automatic ocpw_pkg::sample_type sat16(input logic signed [17:0] v);
      if (v > 18'sd32767) begin
         return 16'sh7fff;
      end
      if (v < -18'sd32768) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

   logic [31:0]          sample_store_ff [2][FFT_LEN];
   logic [31:0]          rd_a_ff;
   logic [31:0]          rd_b_ff;

   logic                 advance;
   logic                 s1_valid_ff, s1_valid_in;
   ocpw_pkg::cmd_type    s1_cmd_ff;
   logic                 s2_valid_ff, s2_valid_in;
   ocpw_pkg::cmd_type    s2_cmd_ff, s2_cmd_in;
   logic signed [16:0]   s2_up_re_ff, s2_up_im_ff;
   ocpw_pkg::sample_type s2_dn_re_ff, s2_dn_im_ff;

   ocpw_pkg::sample_type dly_re_ff [DLY_DEPTH];
   ocpw_pkg::sample_type dly_im_ff [DLY_DEPTH];
   logic [DLY_W-1:0]     dly_sel;

   logic                 rsp_valid_ff, rsp_valid_in;
   ocpw_pkg::sample_type rsp_re_ff, rsp_re_in;
   ocpw_pkg::sample_type rsp_im_ff, rsp_im_in;
   logic                 rsp_sl_ff, rsp_sl_in;
   logic                 rsp_bl_ff, rsp_bl_in;

   // whole pipe moves together, held while a result waits
   assign advance     = !rsp_valid_ff || rsp_ready;
   assign cmd_pop     = advance && cmd_avail;
   assign s1_valid_in = cmd_pop && (cmd.kind != ocpw_pkg::CMD_WRITE);

   // store write and two registered reads
   always_ff @(posedge clock) begin
      if (cmd_pop && cmd.kind == ocpw_pkg::CMD_WRITE) begin
         sample_store_ff[cmd.bank][cmd.idx[IDX_W-1:0]] <= {cmd.re, cmd.im};
      end
      if (advance) begin
         rd_a_ff   <= sample_store_ff[cmd.bank][cmd.idx[IDX_W-1:0]];
         rd_b_ff   <= sample_store_ff[cmd.bank][cmd.src[IDX_W-1:0]];
         s1_cmd_ff <= cmd;
      end
   end

   // flank products
   always_comb begin
      s2_valid_in  = s1_valid_ff;
      s2_cmd_in    = s1_cmd_ff;
      s2_cmd_in.re = rd_a_ff[31:16];
      s2_cmd_in.im = rd_a_ff[15:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_cmd_ff   <= s2_cmd_in;
         s2_up_re_ff <= mul_round(rd_a_ff[31:16], UP_FLANK[s1_cmd_ff.pos]);
         s2_up_im_ff <= mul_round(rd_a_ff[15:0], UP_FLANK[s1_cmd_ff.pos]);
         s2_dn_re_ff <= sat16(18'(mul_round(rd_b_ff[31:16], DOWN_FLANK[s1_cmd_ff.pos])));
         s2_dn_im_ff <= sat16(18'(mul_round(rd_b_ff[15:0], DOWN_FLANK[s1_cmd_ff.pos])));
      end
   end

   // delay line add and output selection
   assign dly_sel = s2_cmd_ff.pos[DLY_W-1:0];

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_re_in    = rsp_re_ff;
      rsp_im_in    = rsp_im_ff;
      rsp_sl_in    = rsp_sl_ff;
      rsp_bl_in    = rsp_bl_ff;
      if (advance) begin
         rsp_valid_in = s2_valid_ff;
         rsp_sl_in    = s2_cmd_ff.symbol_last;
         rsp_bl_in    = s2_cmd_ff.burst_last;
         if (s2_cmd_ff.kind == ocpw_pkg::CMD_TAIL) begin
            rsp_re_in = dly_re_ff[dly_sel];
            rsp_im_in = dly_im_ff[dly_sel];
         end else if (s2_cmd_ff.windowed) begin
            rsp_re_in = sat16(18'(s2_up_re_ff) + 18'(dly_re_ff[dly_sel]));
            rsp_im_in = sat16(18'(s2_up_im_ff) + 18'(dly_im_ff[dly_sel]));
         end else begin
            rsp_re_in = s2_cmd_ff.re;
            rsp_im_in = s2_cmd_ff.im;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < DLY_DEPTH; i++) begin
            dly_re_ff[i] <= '0;
            dly_im_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            s1_valid_ff <= s1_valid_in;
            s2_valid_ff <= s2_valid_in;
            if (s2_valid_ff) begin
               if (s2_cmd_ff.kind == ocpw_pkg::CMD_TAIL) begin
                  if (s2_cmd_ff.burst_last) begin
                     for (int i = 0; i < DLY_DEPTH; i++) begin
                        dly_re_ff[i] <= '0;
                        dly_im_ff[i] <= '0;
                     end
                  end
               end else if (s2_cmd_ff.windowed) begin
                  dly_re_ff[dly_sel] <= s2_dn_re_ff;
                  dly_im_ff[dly_sel] <= s2_dn_im_ff;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_re_ff <= rsp_re_in;
      rsp_im_ff <= rsp_im_in;
      rsp_sl_ff <= rsp_sl_in;
      rsp_bl_ff <= rsp_bl_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_re      = rsp_re_ff;
   assign rsp_out_im      = rsp_im_ff;
   assign rsp_symbol_last = rsp_sl_ff;
   assign rsp_burst_last  = rsp_bl_ff;

endmodule

### sv/ofdm_cyclic_prefix_window_core.sv
// ----------------------------------------------------------------------------
// ofdm_cyclic_prefix_window_core
// cyclic prefix insertion with raised cosine edge windowing
// ----------------------------------------------------------------------------
// Samples (op write) fill two banks of FFT_LEN complex Q1.15 samples; each read
// tick beat returns one output sample of a full bank, prefix first (taken from
// the symbol tail) and then the body, prefix_len + FFT_LEN beats per symbol.
// With window_on set and ROLLOFF_LEN of 2 or more, the first ROLLOFF_LEN-1
// outputs of a symbol are scaled by the rising flank and summed with the delay
// line, which then holds the symbol's first body samples scaled by the falling
// flank; an end-of-burst beat makes later read ticks return that tail first.
// Writes into a full bank are dropped. One request beat is taken per clock as
// long as the four-entry command queue has room and reset is low; the queue
// drains at one command per clock while the back end advances, into a
// three-stage back end (registered store read, flank multiply, delay add and
// output register); a read tick's result passes the queue and these stages
// in order, and waits longer when earlier commands wait in the queue or a
// result is held. The whole back end holds while a result waits, so
// sustained rate is one beat per clock when the response side is ready.
// prefix_len is sampled when a symbol starts. Store entries have no reset.
// ----------------------------------------------------------------------------
module ofdm_cyclic_prefix_window_core #(
   parameter int FFT_LEN     = 64,
   parameter int ROLLOFF_LEN = 2
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_op,
   input  ocpw_pkg::sample_type             req_sample_re,
   input  ocpw_pkg::sample_type             req_sample_im,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output ocpw_pkg::sample_type             rsp_out_re,
   output ocpw_pkg::sample_type             rsp_out_im,
   output logic                             rsp_symbol_last,
   output logic                             rsp_burst_last,
   // register writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ocpw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ocpw_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic [ocpw_pkg::PREFIX_W-1:0] prefix_len_ff, prefix_len_in;
   logic                          window_on_ff, window_on_in;

   logic              fifo_push;
   logic              fifo_full;
   logic              fifo_pop;
   logic              fifo_avail;
   ocpw_pkg::cmd_type push_cmd;
   ocpw_pkg::cmd_type head_cmd;

   // registers take a write whenever reset is low, unknown indexes are ignored
   assign csr_ready = !reset;

   always_comb begin
      prefix_len_in = prefix_len_ff;
      window_on_in  = window_on_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            ocpw_pkg::CSR_PREFIX_LEN: prefix_len_in = csr_wdata[ocpw_pkg::PREFIX_W-1:0];
            ocpw_pkg::CSR_WINDOW_ON:  window_on_in  = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_len_ff <= ocpw_pkg::PREFIX_W'(16);
         window_on_ff  <= 1'b1;
      end else begin
         prefix_len_ff <= prefix_len_in;
         window_on_ff  <= window_on_in;
      end
   end

   // front: bank bookkeeping and command issue
   ocpw_front #(
      .FFT_LEN     (FFT_LEN),
      .ROLLOFF_LEN (ROLLOFF_LEN)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_sample_re (req_sample_re),
      .req_sample_im (req_sample_im),
      .prefix_len    (prefix_len_ff),
      .window_on     (window_on_ff),
      .fifo_full     (fifo_full),
      .fifo_push     (fifo_push),
      .fifo_cmd      (push_cmd)
   );

   // decoupling queue
   ocpw_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_cmd  (push_cmd),
      .full      (fifo_full),
      .pop       (fifo_pop),
      .not_empty (fifo_avail),
      .head_cmd  (head_cmd)
   );

   // back: store, windowing datapath, output register
   ocpw_back #(
      .FFT_LEN     (FFT_LEN),
      .ROLLOFF_LEN (ROLLOFF_LEN)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_avail       (fifo_avail),
      .cmd             (head_cmd),
      .cmd_pop         (fifo_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_re      (rsp_out_re),
      .rsp_out_im      (rsp_out_im),
      .rsp_symbol_last (rsp_symbol_last),
      .rsp_burst_last  (rsp_burst_last)
   );

   // a tail sample never closes a symbol
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_symbol_last && rsp_burst_last))
      else $error("tail beat flagged as symbol end");

   // the front never pushes into a full queue
   assert property (@(posedge clock) disable iff (reset)
      fifo_push |-> !fifo_full)
      else $error("command queue overflow");

   // back only pops what is there
   assert property (@(posedge clock) disable iff (reset)
      fifo_pop |-> fifo_avail)
      else $error("command queue underflow");

   // no result right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

### bench/tb_ofdm_cyclic_prefix_window_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ofdm_cyclic_prefix_window_core
// self-checking bench for cyclic prefix insertion with edge windowing
// ----------------------------------------------------------------------------
// Drives write, read tick, end-of-burst and unknown-op beats with random gaps on both
// channels, predicts every output sample in a scoreboard of its own and
// compares the response beats in order. Register settings change between
// phases once the core has drained.
// ----------------------------------------------------------------------------
module tb_ofdm_cyclic_prefix_window_core;

   localparam int FFT_LEN      = 64;
   localparam int ROLLOFF_LEN  = 2;
   localparam int FLANK_DEPTH  = ROLLOFF_LEN + 1;
   localparam int GAP_MAX      = 11;
   localparam int LONG_HOLD    = 200;     // receiver hold-off that fills the core
   localparam int DRAIN_CYCLES = 24;      // covers queue plus back end latency
   localparam int CYCLE_LIMIT  = 600000;
   localparam int TARGET_ITEMS = 1100;
   localparam int PHASE_ITEMS  = 140;

   // op value the core has to ignore
   localparam logic [1:0] OP_UNUSED = 2'd3;
   // register index with no register behind it
   localparam logic [ocpw_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      ocpw_pkg::sample_type re;
      ocpw_pkg::sample_type im;
      logic                 symbol_last;
      logic                 burst_last;
   } out_beat_type;

   // -------------------------------------------------------------------------
   // scoreboard: own copy of banks, delay line and registers
   // -------------------------------------------------------------------------
   class cp_window_tracker;
      ocpw_pkg::sample_type bank_re [2][FFT_LEN];
      ocpw_pkg::sample_type bank_im [2][FFT_LEN];
      ocpw_pkg::sample_type line_re [FLANK_DEPTH];
      ocpw_pkg::sample_type line_im [FLANK_DEPTH];
      int unsigned  up_gain [FLANK_DEPTH];
      int unsigned  down_gain [FLANK_DEPTH];
      int           wr_pos;
      int           rd_pos;
      int           sym_prefix;
      int           tail_idx;
      bit           wr_bank;
      bit           rd_bank;
      bit [1:0]     full;
      bit           tail_pending;
      int           prefix_len;
      bit           window_on;
      out_beat_type expected_beats[$];
      int           errors;
      int           beats_checked;
      int           symbols_seen;
      int           tails_seen;

      function new();
         for (int b = 0; b < 2; b++)
            for (int i = 0; i < FFT_LEN; i++) begin
               bank_re[b][i] = '0;
               bank_im[b][i] = '0;
            end
         for (int i = 0; i < FLANK_DEPTH; i++) begin
            line_re[i]   = '0;
            line_im[i]   = '0;
            up_gain[i]   = 0;
            down_gain[i] = 0;
         end
         for (int i = 1; i < ROLLOFF_LEN; i++) begin
            up_gain[i-1]   = sine_sq(i, ROLLOFF_LEN);
            down_gain[i-1] = sine_sq(ROLLOFF_LEN - i, ROLLOFF_LEN);
         end
         wr_pos = 0; rd_pos = 0; sym_prefix = 0; tail_idx = 0;
         wr_bank = 0; rd_bank = 0; full = '0; tail_pending = 0;
         prefix_len = 16; window_on = 1;
         errors = 0; beats_checked = 0; symbols_seen = 0; tails_seen = 0;
      endfunction

      // sin^2(pi*num/(2*den)) in Q1.15 from a truncated Q2.30 series
      static function int unsigned sine_sq(int unsigned num, int unsigned den);
         longint unsigned x, x2, term, sum;
         x    = 64'd3373259426 * num / longint'(2 * den);
         x2   = (x * x) >> 30;
         term = x;
         sum  = x;
         for (int k = 1; k <= 8; k++) begin
            term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) sum = sum - term;
            else sum = sum + term;
         end
         if (sum > (64'd1 << 30)) sum = 64'd1 << 30;
         return int'((sum * sum + (64'd1 << 44)) >> 45);
      endfunction

      // sample times flank, rounded half up
      static function int scale(int s, int unsigned f);
         longint p;
         p = longint'(s) * longint'(f) + 16384;
         return int'(p >>> 15);
      endfunction

      static function ocpw_pkg::sample_type clip16(int v);
         if (v > 32767) return 16'sh7fff;
         if (v < -32768) return 16'sh8000;
         return ocpw_pkg::sample_type'(v);
      endfunction

      function bit window_active();
         return window_on && (ROLLOFF_LEN >= 2);
      endfunction

      function void set_register(logic [ocpw_pkg::CSR_INDEX_W-1:0] idx,
                                 logic [ocpw_pkg::CSR_DATA_W-1:0] data);
         if (idx == ocpw_pkg::CSR_PREFIX_LEN)
            prefix_len = int'(data[ocpw_pkg::PREFIX_W-1:0]);
         else if (idx == ocpw_pkg::CSR_WINDOW_ON)
            window_on = data[0];
      endfunction

      // advance the prediction by one accepted request beat;
      // returns 1 when the beat changed state or produced a sample
      function bit take_request(logic [1:0] op, ocpw_pkg::sample_type re,
                                ocpw_pkg::sample_type im);
         int           idx, b, total, t;
         int           acc_re, acc_im;
         bit           is_last;
         out_beat_type beat;
         if (op == ocpw_pkg::OP_WRITE) begin
            if (full[wr_bank]) return 0;           // both banks busy, dropped
            bank_re[wr_bank][wr_pos % FFT_LEN] = re;
            bank_im[wr_bank][wr_pos % FFT_LEN] = im;
            wr_pos++;
            if (wr_pos >= FFT_LEN) begin
               wr_pos = 0;
               full[wr_bank] = 1'b1;
               wr_bank = !wr_bank;
            end
            return 1;
         end
         if (op == ocpw_pkg::OP_END) begin
            if (tail_pending || !window_active()) return 0;
            tail_pending = 1;
            tail_idx = 0;
            return 1;
         end
         if (op != ocpw_pkg::OP_READ) return 0;

         if (rd_pos == 0) begin
            if (tail_pending) begin
               t = tail_idx % FLANK_DEPTH;
               beat.re = line_re[t];
               beat.im = line_im[t];
               beat.symbol_last = 1'b0;
               beat.burst_last = (tail_idx >= ROLLOFF_LEN - 2);
               expected_beats.push_back(beat);
               if (tail_idx >= ROLLOFF_LEN - 2) begin
                  for (int i = 0; i < FLANK_DEPTH; i++) begin
                     line_re[i] = '0;
                     line_im[i] = '0;
                  end
                  tail_pending = 0;
                  tail_idx = 0;
               end else begin
                  tail_idx++;
               end
               return 1;
            end
            if (!full[rd_bank]) return 0;
            sym_prefix = prefix_len;
         end

         total   = sym_prefix + FFT_LEN;
         idx     = (rd_pos + 64 * FFT_LEN - sym_prefix) % FFT_LEN;
         acc_re  = int'(bank_re[rd_bank][idx]);
         acc_im  = int'(bank_im[rd_bank][idx]);
         is_last = (rd_pos + 1 >= total);
         if (window_active() && rd_pos + 1 < ROLLOFF_LEN) begin
            b = rd_pos % FFT_LEN;
            acc_re = scale(acc_re, up_gain[rd_pos]) + int'(line_re[rd_pos]);
            acc_im = scale(acc_im, up_gain[rd_pos]) + int'(line_im[rd_pos]);
            line_re[rd_pos] = clip16(scale(int'(bank_re[rd_bank][b]), down_gain[rd_pos]));
            line_im[rd_pos] = clip16(scale(int'(bank_im[rd_bank][b]), down_gain[rd_pos]));
         end
         beat.re = clip16(acc_re);
         beat.im = clip16(acc_im);
         beat.symbol_last = is_last;
         beat.burst_last = 1'b0;
         expected_beats.push_back(beat);
         if (is_last) begin
            rd_pos = 0;
            full[rd_bank] = 1'b0;
            rd_bank = !rd_bank;
         end else begin
            rd_pos++;
         end
         return 1;
      endfunction

      function void check_beat(ocpw_pkg::sample_type re, ocpw_pkg::sample_type im,
                               logic sl, logic bl);
         out_beat_type want;
         beats_checked++;
         if (expected_beats.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: unexpected beat re=%0d im=%0d sl=%0b bl=%0b",
                        re, im, sl, bl);
            return;
         end
         want = expected_beats.pop_front();
         if (sl) symbols_seen++;
         if (bl) tails_seen++;
         if (re !== want.re || im !== want.im || sl !== want.symbol_last ||
             bl !== want.burst_last) begin
            errors++;
            if (errors <= 10)
               $display({"mismatch at beat %0d: expected re=%0d im=%0d sl=%0b bl=%0b,",
                         " got re=%0d im=%0d sl=%0b bl=%0b"},
                        beats_checked, want.re, want.im, want.symbol_last,
                        want.burst_last, re, im, sl, bl);
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // signals and core
   // -------------------------------------------------------------------------
   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic [1:0]                       req_op = ocpw_pkg::OP_WRITE;
   ocpw_pkg::sample_type             req_sample_re = '0;
   ocpw_pkg::sample_type             req_sample_im = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   ocpw_pkg::sample_type             rsp_out_re;
   ocpw_pkg::sample_type             rsp_out_im;
   logic                             rsp_symbol_last;
   logic                             rsp_burst_last;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [ocpw_pkg::CSR_INDEX_W-1:0] csr_index = ocpw_pkg::CSR_PREFIX_LEN;
   logic [ocpw_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   cp_window_tracker sb;

   int  cycle_count = 0;
   int  items_sent = 0;        // every accepted request beat
   int  items_done = 0;        // beats that did something in the core
   int  rsp_seen = 0;
   int  rx_hold = 0;
   bit  rx_fast = 0;
   bit  tx_fast = 0;
   int  cur_prefix = 16;
   int  settings_used = 0;

   ofdm_cyclic_prefix_window_core #(
      .FFT_LEN     (FFT_LEN),
      .ROLLOFF_LEN (ROLLOFF_LEN)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_sample_re   (req_sample_re),
      .req_sample_im   (req_sample_im),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_re      (rsp_out_re),
      .rsp_out_im      (rsp_out_im),
      .rsp_symbol_last (rsp_symbol_last),
      .rsp_burst_last  (rsp_burst_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // 8 ns clock
   initial begin
      forever #4 clock = ~clock;
   end

   // watchdog on the whole run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Some tests failed");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // response side: random stalls, two long hold-offs, in-order check
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         sb.check_beat(rsp_out_re, rsp_out_im, rsp_symbol_last, rsp_burst_last);
         rsp_seen = rsp_seen + 1;
         if ($urandom_range(0, 39) == 0) rx_fast = !rx_fast;
         // long hold-off while the sender keeps pushing: queue fills, req stalls
         if (rsp_seen == 150 || rsp_seen == 700) rx_hold = LONG_HOLD;
         else if (rx_fast) rx_hold = 0;
         else rx_hold = $urandom_range(0, GAP_MAX);
         rsp_ready <= (rx_hold == 0);
      end else begin
         if (rx_hold > 0) rx_hold = rx_hold - 1;
         rsp_ready <= (rx_hold == 0);
      end
   end

   // -------------------------------------------------------------------------
   // request side
   // -------------------------------------------------------------------------

   // extremes show up often so saturation and sign edges get hit
   function automatic ocpw_pkg::sample_type rand_sample();
      case ($urandom_range(0, 7))
         0:       return 16'sh8000;
         1:       return 16'sh7fff;
         2:       return 16'sd0;
         3:       return -16'sd1;
         default: return ocpw_pkg::sample_type'($urandom);
      endcase
   endfunction

   // one request beat; valid stays high across back-to-back beats
   task automatic send_item(input logic [1:0] op, input ocpw_pkg::sample_type re,
                            input ocpw_pkg::sample_type im);
      int gap;
      gap = tx_fast ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_op        <= op;
      req_sample_re <= re;
      req_sample_im <= im;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (sb.take_request(op, re, im)) items_done++;
      items_sent++;
      if ($urandom_range(0, 39) == 0) tx_fast = !tx_fast;
   endtask

   task automatic send_read();
      send_item(ocpw_pkg::OP_READ, rand_sample(), rand_sample());
   endtask

   // wait until every predicted sample is out, then let the back end empty
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.expected_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // register beat; caller lowers csr_valid after the last one
   task automatic write_reg(input logic [ocpw_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [ocpw_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_register(idx, data);
   endtask

   task automatic apply_settings(input int pfx, input bit win, input bit touch_unused);
      logic [ocpw_pkg::CSR_DATA_W-1:0] junk;
      settle();
      junk = ocpw_pkg::CSR_DATA_W'($urandom);
      write_reg(ocpw_pkg::CSR_PREFIX_LEN, ocpw_pkg::CSR_DATA_W'(pfx));
      // upper bits of the window register are don't-care
      write_reg(ocpw_pkg::CSR_WINDOW_ON, {junk[ocpw_pkg::CSR_DATA_W-1:1], win});
      if (touch_unused) write_reg(CSR_UNUSED, junk);
      csr_valid <= 1'b0;
      cur_prefix = pfx;
      settings_used++;
   endtask

   // full symbol (sometimes two plus dropped writes), then its read ticks,
   // with an end of burst dropped in among the reads now and then
   task automatic symbol_chunk();
      int n_writes, n_reads, end_at;
      n_writes = ($urandom_range(0, 4) == 0) ? 2 * FFT_LEN + $urandom_range(1, 8)
                                             : FFT_LEN;
      for (int k = 0; k < n_writes; k++)
         send_item(ocpw_pkg::OP_WRITE, rand_sample(), rand_sample());
      n_reads = ((n_writes > FFT_LEN) ? 2 : 1) * (cur_prefix + FFT_LEN)
                + $urandom_range(0, 3);
      end_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, n_reads - 1) : -1;
      for (int k = 0; k < n_reads; k++) begin
         if (k == end_at) send_item(ocpw_pkg::OP_END, rand_sample(), rand_sample());
         send_read();
      end
      if (end_at >= 0) send_read();      // room for the tail sample
   endtask

   // writes and reads interleaved, mostly well formed
   task automatic mixed_chunk();
      int r;
      for (int k = 0; k < 40; k++) begin
         r = $urandom_range(0, 19);
         if (r < 9) send_item(ocpw_pkg::OP_WRITE, rand_sample(), rand_sample());
         else if (r < 18) send_read();
         else if (r == 18) send_item(ocpw_pkg::OP_END, rand_sample(), rand_sample());
         else send_item(OP_UNUSED, rand_sample(), rand_sample());
      end
   endtask

   // any op, any payload
   task automatic noise_chunk();
      for (int k = 0; k < 12; k++)
         send_item(2'($urandom_range(0, 3)), rand_sample(), rand_sample());
   endtask

   // -------------------------------------------------------------------------
   // main sequence
   // -------------------------------------------------------------------------
   initial begin
      int  phase, chunk_no, phase_start, pfx, r;
      bit  win;
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed part at reset settings (prefix 16, windowing on)
      send_read();                                              // nothing to send
      send_item(OP_UNUSED, 16'sh7fff, 16'sh8000);               // unknown op
      send_item(ocpw_pkg::OP_END, 16'sd0, 16'sd0);              // burst starts ending
      send_item(ocpw_pkg::OP_END, -16'sd1, 16'sd1);             // already ending, ignored
      send_read();                                              // tail of an empty delay line
      send_read();                                              // nothing left again
      send_item(ocpw_pkg::OP_WRITE, 16'sh7fff, 16'sh7fff);
      send_item(ocpw_pkg::OP_WRITE, 16'sh8000, 16'sh8000);
      send_item(ocpw_pkg::OP_WRITE, 16'sh7fff, 16'sh8000);
      send_item(ocpw_pkg::OP_WRITE, 16'sh8000, 16'sh7fff);
      send_item(ocpw_pkg::OP_WRITE, 16'sd0, 16'sd0);
      send_item(ocpw_pkg::OP_WRITE, -16'sd1, -16'sd1);
      send_item(ocpw_pkg::OP_WRITE, 16'sd1, -16'sd1);
      send_read();                                              // bank not full yet

      phase = 0;
      while (items_done < TARGET_ITEMS) begin
         case (phase)
            0:       begin pfx = 0;  win = 1; end
            1:       begin pfx = 63; win = 1; end
            2:       begin pfx = 63; win = 0; end
            3:       begin pfx = 0;  win = 0; end
            4:       begin pfx = 16; win = 1; end
            default: begin
               pfx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                 : $urandom_range(0, 20);
               win = $urandom_range(0, 1);
            end
         endcase
         apply_settings(pfx, win, phase == 3);
         chunk_no = 0;
         phase_start = items_done;
         while (items_done - phase_start < PHASE_ITEMS && items_done < TARGET_ITEMS) begin
            r = $urandom_range(0, 19);
            if (r < 12) symbol_chunk();
            else if (r < 17) mixed_chunk();
            else noise_chunk();
            // sender waits for every outstanding sample mid-phase once
            if (phase == 1 && chunk_no == 1) settle();
            chunk_no++;
         end
         phase++;
      end

      settle();
      $display("covered %0d request beats (%0d with effect), %0d response beats",
               items_sent, items_done, rsp_seen);
      $display("%0d symbols and %0d burst tails over %0d register settings",
               sb.symbols_seen, sb.tails_seen, settings_used);
      if (sb.expected_beats.size() != 0)
         $display("%0d expected beats never arrived", sb.expected_beats.size());
      if (sb.errors == 0 && sb.expected_beats.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### ofdm_cyclic_prefix_window_core.f
sv/ocpw_pkg.sv
sv/ocpw_front.sv
sv/ocpw_fifo.sv
sv/ocpw_back.sv
sv/ofdm_cyclic_prefix_window_core.sv
bench/tb_ofdm_cyclic_prefix_window_core.sv
